// ===== hw/rtl/rti_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_pkg: shared types and constants of the ray / triangle intersection block
// Coordinate format, internal widths, axis and status codes, register indexes
// and the sideband word that travels alongside the divider.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // edge vectors, cross products, full normal
  localparam int EDGE_W      = COORD_WIDTH + 1;
  localparam int CROSS_W     = 2 * EDGE_W;
  localparam int NRM_FULL_W  = CROSS_W + 1;

  // reduced normal: 62 magnitude bits plus sign
  localparam int NRM_MAG     = 62;
  localparam int NRM_W       = NRM_MAG + 1;
  localparam int NRM_X_W     = (NRM_FULL_W > NRM_W) ? NRM_FULL_W : NRM_W;
  localparam int SHIFT_W     = $clog2(NRM_X_W - NRM_MAG + 1);

  // split of the reduced normal for the dot products
  localparam int NLO_W       = 31;
  localparam int NHI_W       = NRM_W - NLO_W;

  localparam int DEN_W       = NRM_W + COORD_WIDTH + 2;
  localparam int NUM_W       = NRM_W + EDGE_W + 2;
  localparam int REM_W       = DEN_W + 1;
  localparam int OVF_W       = DEN_W + COORD_WIDTH;

  localparam int REG_IDX_W   = 2;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z = 2'd2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef coord_t [2:0]                  vec3_t;
  typedef logic signed [EDGE_W-1:0]      edge_t;
  typedef logic signed [CROSS_W-1:0]     cross_t;
  typedef logic signed [NRM_FULL_W-1:0]  nrmf_t;
  typedef logic signed [NRM_X_W-1:0]     nrmx_t;
  typedef logic signed [NRM_W-1:0]       nrm_t;
  typedef logic signed [DEN_W-1:0]       den_t;
  typedef logic signed [NUM_W-1:0]       num_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    ST_PARALLEL = 2'd0,
    ST_OUTSIDE  = 2'd1,
    ST_HIT      = 2'd2
  } status_t;

  // everything the back end needs besides the quotient
  typedef struct packed {
    logic  par;
    logic  neg;
    vec3_t d;
    vec3_t pa;
    vec3_t pb;
    axis_t ua;
    axis_t ub;
  } side_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ray_triangle_intersect_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_triangle_intersect_top: pipelined ray / triangle intersection test
// Usage:
//   Write the ray origin through cfg_we / cfg_index / cfg_data (index 0..2 for
//   x, y, z, Q16.16) while no word is in flight; other indexes are dropped.
//   A word (direction and three corners) is taken at each edge where start is
//   high and busy is low. busy stays low: the pipeline takes a word every
//   cycle, so the sustained rate is one test per clock.
//   Each result shows on status / hit_* / clamped for exactly one cycle with
//   done high. Results leave in the order the words came in.
//   Most of the depth is the divider for the ray parameter: one quotient bit per
//   stage; ten front-end stages form the normal and the dot products, and six
//   back-end stages form the hit point and the edge sign tests.
//   The receiver cannot hold results off, and nothing inside ever waits.
//   Reset (synchronous, rst high) clears the origin to zero and drops every
//   word still in flight.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  cfg_we,
  input  logic [rti_pkg::REG_IDX_W-1:0]         cfg_index,
  input  logic signed [rti_pkg::COORD_WIDTH-1:0] cfg_data,
  input  logic signed [rti_pkg::COORD_WIDTH-1:0] dir_x,
  input  logic signed [rti_pkg::COORD_WIDTH-1:0] dir_y,
  input  logic signed [rti_pkg::COORD_WIDTH-1:0] dir_z,
  input  logic signed [rti_pkg::COORD_WIDTH-1:0] v0_x,
  input  logic signed [rti_pkg::COORD_WIDTH-1:0] v0_y,
  input  logic signed [rti_pkg::COORD_WIDTH-1:0] v0_z,
  input  logic signed [rti_pkg::COORD_WIDTH-1:0] v1_x,
  input  logic signed [rti_pkg::COORD_WIDTH-1:0] v1_y,
  input  logic signed [rti_pkg::COORD_WIDTH-1:0] v1_z,
  input  logic signed [rti_pkg::COORD_WIDTH-1:0] v2_x,
  input  logic signed [rti_pkg::COORD_WIDTH-1:0] v2_y,
  input  logic signed [rti_pkg::COORD_WIDTH-1:0] v2_z,
  output logic                                  done,
  output logic [1:0]                            status,
  output logic signed [rti_pkg::COORD_WIDTH-1:0] hit_x,
  output logic signed [rti_pkg::COORD_WIDTH-1:0] hit_y,
  output logic signed [rti_pkg::COORD_WIDTH-1:0] hit_z,
  output logic                                  clamped
);

  localparam int CW     = rti_pkg::COORD_WIDTH;
  localparam int FB     = rti_pkg::FRAC_BITS;
  localparam int DLO_W  = rti_pkg::NLO_W + 1 + CW;
  localparam int DHI_W  = rti_pkg::NHI_W + CW;
  localparam int NLO_PW = rti_pkg::NLO_W + 1 + rti_pkg::EDGE_W;
  localparam int NHI_PW = rti_pkg::NHI_W + rti_pkg::EDGE_W;
  localparam int VW     = 2 * CW - FB + 2;

  // pipeline takes a word every cycle
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // origin registers
  rti_pkg::vec3_t origin;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rti_pkg::REG_ORIGIN_X: origin[0] <= cfg_data;
        rti_pkg::REG_ORIGIN_Y: origin[1] <= cfg_data;
        rti_pkg::REG_ORIGIN_Z: origin[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // S1: edges and corner offset from the origin
  rti_pkg::vec3_t in_d;
  rti_pkg::vec3_t in_p [3];

  assign in_d    = {dir_z, dir_y, dir_x};
  assign in_p[0] = {v0_z, v0_y, v0_x};
  assign in_p[1] = {v1_z, v1_y, v1_x};
  assign in_p[2] = {v2_z, v2_y, v2_x};

  logic            v1;
  rti_pkg::vec3_t  s1_d;
  rti_pkg::vec3_t  s1_p [3];
  rti_pkg::edge_t  s1_e1 [3];
  rti_pkg::edge_t  s1_e2 [3];
  rti_pkg::edge_t  s1_po [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    s1_d <= in_d;
    for (int i = 0; i < 3; i++) begin
      s1_p[i] <= in_p[i];
    end
    for (int c = 0; c < 3; c++) begin
      s1_e1[c] <= rti_pkg::edge_t'(in_p[1][c]) - rti_pkg::edge_t'(in_p[0][c]);
      s1_e2[c] <= rti_pkg::edge_t'(in_p[2][c]) - rti_pkg::edge_t'(in_p[0][c]);
      s1_po[c] <= rti_pkg::edge_t'(in_p[0][c]) - rti_pkg::edge_t'(origin[c]);
    end
  end

  // --------------------------------------------------------------------------
  // S2: cross product terms
  logic            v2;
  rti_pkg::vec3_t  s2_d;
  rti_pkg::vec3_t  s2_p [3];
  rti_pkg::edge_t  s2_po [3];
  rti_pkg::cross_t s2_a [3];
  rti_pkg::cross_t s2_b [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    s2_d  <= s1_d;
    s2_p  <= s1_p;
    s2_po <= s1_po;
    s2_a[0] <= s1_e1[1] * s1_e2[2];
    s2_b[0] <= s1_e1[2] * s1_e2[1];
    s2_a[1] <= s1_e1[2] * s1_e2[0];
    s2_b[1] <= s1_e1[0] * s1_e2[2];
    s2_a[2] <= s1_e1[0] * s1_e2[1];
    s2_b[2] <= s1_e1[1] * s1_e2[0];
  end

  // --------------------------------------------------------------------------
  // S3: full normal
  logic            v3;
  rti_pkg::vec3_t  s3_d;
  rti_pkg::vec3_t  s3_p [3];
  rti_pkg::edge_t  s3_po [3];
  rti_pkg::nrmf_t  s3_n [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    s3_d  <= s2_d;
    s3_p  <= s2_p;
    s3_po <= s2_po;
    for (int c = 0; c < 3; c++) begin
      s3_n[c] <= rti_pkg::nrmf_t'(s2_a[c]) - rti_pkg::nrmf_t'(s2_b[c]);
    end
  end

  // --------------------------------------------------------------------------
  // S4: shift needed to bring the largest component into 62 bits
  logic [rti_pkg::NRM_FULL_W-1:0] mag_or;
  logic [rti_pkg::SHIFT_W-1:0]    k_next;

  always_comb begin
    mag_or = '0;
    for (int c = 0; c < 3; c++) begin
      mag_or = mag_or | (s3_n[c][rti_pkg::NRM_FULL_W-1] ? -s3_n[c] : s3_n[c]);
    end
    k_next = '0;
    for (int b = rti_pkg::NRM_MAG; b < rti_pkg::NRM_FULL_W; b++) begin
      if (mag_or[b]) begin
        k_next = rti_pkg::SHIFT_W'(b - rti_pkg::NRM_MAG + 1);
      end
    end
  end

  logic                        v4;
  rti_pkg::vec3_t              s4_d;
  rti_pkg::vec3_t              s4_p [3];
  rti_pkg::edge_t              s4_po [3];
  rti_pkg::nrmf_t              s4_n [3];
  logic [rti_pkg::SHIFT_W-1:0] s4_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    s4_d  <= s3_d;
    s4_p  <= s3_p;
    s4_po <= s3_po;
    s4_n  <= s3_n;
    s4_k  <= k_next;
  end

  // --------------------------------------------------------------------------
  // S5: reduced normal (floor shift)
  rti_pkg::nrm_t s5_n_next [3];

  always_comb begin
    rti_pkg::nrmx_t wide;
    for (int c = 0; c < 3; c++) begin
      wide = rti_pkg::nrmx_t'(s4_n[c]);
      s5_n_next[c] = rti_pkg::nrm_t'(wide >>> s4_k);
    end
  end

  logic            v5;
  rti_pkg::vec3_t  s5_d;
  rti_pkg::vec3_t  s5_p [3];
  rti_pkg::edge_t  s5_po [3];
  rti_pkg::nrm_t   s5_n [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    s5_d  <= s4_d;
    s5_p  <= s4_p;
    s5_po <= s4_po;
    s5_n  <= s5_n_next;
  end

  // --------------------------------------------------------------------------
  // S6: dot product partial products, projection axes
  logic [rti_pkg::NRM_W-1:0] an [3];
  rti_pkg::side_t            s6_sd_next;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      an[c] = s5_n[c][rti_pkg::NRM_W-1] ? -s5_n[c] : s5_n[c];
    end
    s6_sd_next     = '0;
    s6_sd_next.d   = s5_d;
    // drop the dominant axis; ties drop x, then y
    if (an[0] >= an[1] && an[0] >= an[2]) begin
      s6_sd_next.ua = rti_pkg::AXIS_Y;
      s6_sd_next.ub = rti_pkg::AXIS_Z;
    end else if (an[1] >= an[2]) begin
      s6_sd_next.ua = rti_pkg::AXIS_X;
      s6_sd_next.ub = rti_pkg::AXIS_Z;
    end else begin
      s6_sd_next.ua = rti_pkg::AXIS_X;
      s6_sd_next.ub = rti_pkg::AXIS_Y;
    end
    for (int i = 0; i < 3; i++) begin
      s6_sd_next.pa[i] = s5_p[i][s6_sd_next.ua];
      s6_sd_next.pb[i] = s5_p[i][s6_sd_next.ub];
    end
  end

  logic                       v6;
  rti_pkg::side_t             s6_sd;
  logic signed [DLO_W-1:0]    s6_dlo [3];
  logic signed [DHI_W-1:0]    s6_dhi [3];
  logic signed [NLO_PW-1:0]   s6_nlo [3];
  logic signed [NHI_PW-1:0]   s6_nhi [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    s6_sd <= s6_sd_next;
    for (int c = 0; c < 3; c++) begin
      s6_dlo[c] <= $signed({1'b0, s5_n[c][rti_pkg::NLO_W-1:0]}) * s5_d[c];
      s6_dhi[c] <= $signed(s5_n[c][rti_pkg::NRM_W-1:rti_pkg::NLO_W]) * s5_d[c];
      s6_nlo[c] <= $signed({1'b0, s5_n[c][rti_pkg::NLO_W-1:0]}) * s5_po[c];
      s6_nhi[c] <= $signed(s5_n[c][rti_pkg::NRM_W-1:rti_pkg::NLO_W]) * s5_po[c];
    end
  end

  // --------------------------------------------------------------------------
  // S7: per-component dot product terms
  logic           v7;
  rti_pkg::side_t s7_sd;
  rti_pkg::den_t  s7_den [3];
  rti_pkg::num_t  s7_num [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    s7_sd <= s6_sd;
    for (int c = 0; c < 3; c++) begin
      s7_den[c] <= (rti_pkg::den_t'(s6_dhi[c]) <<< rti_pkg::NLO_W) + rti_pkg::den_t'(s6_dlo[c]);
      s7_num[c] <= (rti_pkg::num_t'(s6_nhi[c]) <<< rti_pkg::NLO_W) + rti_pkg::num_t'(s6_nlo[c]);
    end
  end

  // --------------------------------------------------------------------------
  // S8: dot products
  logic           v8;
  rti_pkg::side_t s8_sd;
  rti_pkg::den_t  s8_den;
  rti_pkg::num_t  s8_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
    s8_sd  <= s7_sd;
    s8_den <= s7_den[0] + s7_den[1] + s7_den[2];
    s8_num <= s7_num[0] + s7_num[1] + s7_num[2];
  end

  // --------------------------------------------------------------------------
  // S9: signs and magnitudes
  rti_pkg::side_t s9_sd_next;

  always_comb begin
    s9_sd_next     = s8_sd;
    s9_sd_next.par = (s8_den == '0);
    s9_sd_next.neg = s8_num[rti_pkg::NUM_W-1] ^ s8_den[rti_pkg::DEN_W-1];
  end

  logic                      v9;
  rti_pkg::side_t            s9_sd;
  logic [rti_pkg::DEN_W-1:0] s9_dabs;
  logic [rti_pkg::NUM_W-1:0] s9_nabs;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= v8;
    end
    s9_sd   <= s9_sd_next;
    s9_dabs <= s8_den[rti_pkg::DEN_W-1] ? -s8_den : s8_den;
    s9_nabs <= s8_num[rti_pkg::NUM_W-1] ? -s8_num : s8_num;
  end

  // --------------------------------------------------------------------------
  // S10: overflow check and divider seed
  logic                      v10;
  rti_pkg::side_t            s10_sd;
  logic                      s10_ovf;
  logic [rti_pkg::REM_W-1:0] s10_rem;
  logic [rti_pkg::DEN_W-1:0] s10_den;
  logic [CW-1:0]             s10_tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else begin
      v10 <= v9;
    end
    s10_sd   <= s9_sd;
    s10_den  <= s9_dabs;
    // quotient of |num| * 2^FB / |den| needs more than CW bits
    s10_ovf  <= rti_pkg::OVF_W'(s9_nabs) >= (rti_pkg::OVF_W'(s9_dabs) << (CW - FB));
    s10_rem  <= rti_pkg::REM_W'(s9_nabs >> (CW - FB));
    s10_tail <= {s9_nabs[CW-FB-1:0], {FB{1'b0}}};
  end

  // --------------------------------------------------------------------------
  // divider
  logic           div_valid;
  rti_pkg::side_t div_sd;
  logic           div_ovf;
  logic [CW-1:0]  div_q;

  rti_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v10),
    .in_side   (s10_sd),
    .in_ovf    (s10_ovf),
    .in_rem    (s10_rem),
    .in_den    (s10_den),
    .in_tail   (s10_tail),
    .out_valid (div_valid),
    .out_side  (div_sd),
    .out_ovf   (div_ovf),
    .out_q     (div_q)
  );

  // --------------------------------------------------------------------------
  // SA: signed, saturated ray parameter
  rti_pkg::coord_t t_next;
  logic            ct_next;

  always_comb begin
    t_next  = '0;
    ct_next = 1'b0;
    if (!div_sd.neg) begin
      if (div_ovf || div_q[CW-1]) begin
        t_next  = rti_pkg::COORD_MAX;
        ct_next = 1'b1;
      end else begin
        t_next = div_q;
      end
    end else begin
      if (div_ovf || (div_q[CW-1] && (|div_q[CW-2:0]))) begin
        t_next  = rti_pkg::COORD_MIN;
        ct_next = 1'b1;
      end else begin
        t_next = -div_q;
      end
    end
  end

  logic            va;
  rti_pkg::side_t  sa_sd;
  rti_pkg::coord_t sa_t;
  logic            sa_ct;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= div_valid;
    end
    sa_sd <= div_sd;
    sa_t  <= t_next;
    sa_ct <= ct_next;
  end

  // --------------------------------------------------------------------------
  // SB: D * t
  logic                     vb;
  rti_pkg::side_t           sb_sd;
  logic                     sb_ct;
  logic signed [2*CW-1:0]   sb_p [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    sb_sd <= sa_sd;
    sb_ct <= sa_ct;
    for (int c = 0; c < 3; c++) begin
      sb_p[c] <= sa_sd.d[c] * sa_t;
    end
  end

  // --------------------------------------------------------------------------
  // SC: hit point, rounded half up, saturated
  logic signed [VW-1:0] sc_v [3];
  rti_pkg::vec3_t       h_next;
  logic                 hc_next;

  always_comb begin
    hc_next = sb_ct;
    for (int c = 0; c < 3; c++) begin
      sc_v[c] = VW'(sb_p[c] >>> FB) + VW'({1'b0, sb_p[c][FB-1]}) + VW'(origin[c]);
      if (sc_v[c] > VW'(rti_pkg::COORD_MAX)) begin
        h_next[c] = rti_pkg::COORD_MAX;
        hc_next   = 1'b1;
      end else if (sc_v[c] < VW'(rti_pkg::COORD_MIN)) begin
        h_next[c] = rti_pkg::COORD_MIN;
        hc_next   = 1'b1;
      end else begin
        h_next[c] = sc_v[c][CW-1:0];
      end
    end
  end

  logic           vc;
  rti_pkg::side_t sc_sd;
  rti_pkg::vec3_t sc_h;
  logic           sc_clamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb;
    end
    sc_sd    <= sb_sd;
    sc_h     <= h_next;
    sc_clamp <= hc_next;
  end

  // --------------------------------------------------------------------------
  // SD: projected edge differences; edge e runs from corner e to the next one
  rti_pkg::coord_t ha;
  rti_pkg::coord_t hb;

  assign ha = sc_h[sc_sd.ua];
  assign hb = sc_h[sc_sd.ub];

  logic           vd;
  rti_pkg::vec3_t sd_h;
  logic           sd_clamp;
  logic           sd_par;
  rti_pkg::edge_t sd_ax [3];
  rti_pkg::edge_t sd_ay [3];
  rti_pkg::edge_t sd_bx [3];
  rti_pkg::edge_t sd_by [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else begin
      vd <= vc;
    end
    sd_h     <= sc_h;
    sd_clamp <= sc_clamp;
    sd_par   <= sc_sd.par;
    for (int e = 0; e < 3; e++) begin
      sd_ax[e] <= rti_pkg::edge_t'(ha) - rti_pkg::edge_t'(sc_sd.pa[(e == 2) ? 0 : e + 1]);
      sd_ay[e] <= rti_pkg::edge_t'(hb) - rti_pkg::edge_t'(sc_sd.pb[(e == 2) ? 0 : e + 1]);
      sd_bx[e] <= rti_pkg::edge_t'(sc_sd.pa[e])
                - rti_pkg::edge_t'(sc_sd.pa[(e == 2) ? 0 : e + 1]);
      sd_by[e] <= rti_pkg::edge_t'(sc_sd.pb[e])
                - rti_pkg::edge_t'(sc_sd.pb[(e == 2) ? 0 : e + 1]);
    end
  end

  // --------------------------------------------------------------------------
  // SE: edge cross terms
  logic            ve;
  rti_pkg::vec3_t  se_h;
  logic            se_clamp;
  logic            se_par;
  rti_pkg::cross_t se_l [3];
  rti_pkg::cross_t se_r [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else begin
      ve <= vd;
    end
    se_h     <= sd_h;
    se_clamp <= sd_clamp;
    se_par   <= sd_par;
    for (int e = 0; e < 3; e++) begin
      se_l[e] <= sd_ax[e] * sd_by[e];
      se_r[e] <= sd_bx[e] * sd_ay[e];
    end
  end

  // --------------------------------------------------------------------------
  // SF: edge signs and result word
  rti_pkg::nrmf_t edge_val [3];
  logic           any_neg;
  logic           any_pos;

  always_comb begin
    any_neg = 1'b0;
    any_pos = 1'b0;
    for (int e = 0; e < 3; e++) begin
      edge_val[e] = rti_pkg::nrmf_t'(se_l[e]) - rti_pkg::nrmf_t'(se_r[e]);
      if (edge_val[e][rti_pkg::NRM_FULL_W-1]) begin
        any_neg = 1'b1;
      end else if (edge_val[e] != '0) begin
        any_pos = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ve;
    end
    if (se_par) begin
      status  <= rti_pkg::ST_PARALLEL;
      hit_x   <= '0;
      hit_y   <= '0;
      hit_z   <= '0;
      clamped <= 1'b0;
    end else begin
      // mixed edge signs put the point outside; zero counts as on the edge
      status  <= (any_neg && any_pos) ? rti_pkg::ST_OUTSIDE : rti_pkg::ST_HIT;
      hit_x   <= se_h[0];
      hit_y   <= se_h[1];
      hit_z   <= se_h[2];
      clamped <= se_clamp;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rti_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_div: pipelined restoring divider
// One quotient bit per stage, COORD_WIDTH stages. The remainder enters already
// reduced below the divisor whenever in_ovf is low; the low dividend bits are shifted in from tail.
// ----------------------------------------------------------------------------
module rti_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  rti_pkg::side_t                     in_side,
  input  logic                               in_ovf,
  input  logic [rti_pkg::REM_W-1:0]          in_rem,
  input  logic [rti_pkg::DEN_W-1:0]          in_den,
  input  logic [rti_pkg::COORD_WIDTH-1:0]    in_tail,
  output logic                               out_valid,
  output rti_pkg::side_t                     out_side,
  output logic                               out_ovf,
  output logic [rti_pkg::COORD_WIDTH-1:0]    out_q
);

  localparam int STEPS = rti_pkg::COORD_WIDTH;

  logic                          vld  [STEPS];
  rti_pkg::side_t                sd   [STEPS];
  logic                          ovf  [STEPS];
  logic [rti_pkg::REM_W-1:0]     rem  [STEPS];
  logic [rti_pkg::DEN_W-1:0]     den  [STEPS];
  logic [STEPS-1:0]              tail [STEPS];
  logic [STEPS-1:0]              q    [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic                      src_vld;
    rti_pkg::side_t            src_sd;
    logic                      src_ovf;
    logic [rti_pkg::REM_W-1:0] src_rem;
    logic [rti_pkg::DEN_W-1:0] src_den;
    logic [STEPS-1:0]          src_tail;
    logic [STEPS-1:0]          src_q;
    logic [rti_pkg::REM_W:0]   trial;
    logic [rti_pkg::REM_W:0]   dext;

    if (s == 0) begin : g_first
      assign src_vld  = in_valid;
      assign src_sd   = in_side;
      assign src_ovf  = in_ovf;
      assign src_rem  = in_rem;
      assign src_den  = in_den;
      assign src_tail = in_tail;
      assign src_q    = '0;
    end else begin : g_next
      assign src_vld  = vld[s-1];
      assign src_sd   = sd[s-1];
      assign src_ovf  = ovf[s-1];
      assign src_rem  = rem[s-1];
      assign src_den  = den[s-1];
      assign src_tail = tail[s-1];
      assign src_q    = q[s-1];
    end

    assign trial = {src_rem, src_tail[STEPS-1]};
    assign dext  = (rti_pkg::REM_W + 1)'(src_den);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= src_vld;
      end
      sd[s]   <= src_sd;
      ovf[s]  <= src_ovf;
      den[s]  <= src_den;
      tail[s] <= {src_tail[STEPS-2:0], 1'b0};
      if (trial >= dext) begin
        rem[s] <= rti_pkg::REM_W'(trial - dext);
        q[s]   <= {src_q[STEPS-2:0], 1'b1};
      end else begin
        rem[s] <= trial[rti_pkg::REM_W-1:0];
        q[s]   <= {src_q[STEPS-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign out_side  = sd[STEPS-1];
  assign out_ovf   = ovf[STEPS-1];
  assign out_q     = q[STEPS-1];

endmodule
`default_nettype wire

// ===== tb/sv/tb_ray_triangle_intersect_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_triangle_intersect_top: self-checking bench for the ray / triangle test
// Drives direction and corner words through the start / busy handshake under a
// set of ray origins, predicts each result in wide signed arithmetic and checks
// every done strobe against the oldest pending prediction, field by field.
// ----------------------------------------------------------------------------
module tb_ray_triangle_intersect_top;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    rti_pkg::vec3_t        dir;
    rti_pkg::vec3_t [2:0]  corner;
  } ray_word_t;

  typedef struct packed {
    rti_pkg::status_t status;
    rti_pkg::coord_t  hx;
    rti_pkg::coord_t  hy;
    rti_pkg::coord_t  hz;
    logic             clamped;
  } hit_result_t;

  localparam logic [rti_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam rti_pkg::coord_t ONE = 32'sh10000;
  localparam int DRAIN_CYCLES = rti_pkg::COORD_WIDTH + 25;

  logic clk, rst, start, busy, cfg_we, done, clamped;
  logic [rti_pkg::REG_IDX_W-1:0] cfg_index;
  rti_pkg::coord_t cfg_data;
  rti_pkg::coord_t dir_x, dir_y, dir_z, v0_x, v0_y, v0_z;
  rti_pkg::coord_t v1_x, v1_y, v1_z, v2_x, v2_y, v2_z;
  rti_pkg::coord_t hit_x, hit_y, hit_z;
  logic [1:0] status;

  rti_pkg::vec3_t origin_copy;
  hit_result_t    pending_hits[$];
  int             fail_count, checked, hit_seen, outside_seen, parallel_seen, clamp_seen;
  bit             no_idle;

  ray_triangle_intersect_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .v0_x(v0_x), .v0_y(v0_y), .v0_z(v0_z),
    .v1_x(v1_x), .v1_y(v1_y), .v1_z(v1_z),
    .v2_x(v2_x), .v2_y(v2_y), .v2_z(v2_z),
    .done(done), .status(status), .hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z),
    .clamped(clamped)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic wide_t widen(logic [31:0] x);
    return {{96{x[31]}}, x};
  endfunction

  function automatic int edge_sign(wide_t ax, wide_t ay, wide_t bx, wide_t by,
                                   wide_t cx, wide_t cy);
    wide_t val;
    val = (ax - cx) * (by - cy) - (bx - cx) * (ay - cy);
    return (val < 0) ? -1 : ((val == 0) ? 0 : 1);
  endfunction

  function automatic hit_result_t predict_intersection(ray_word_t w, rti_pkg::vec3_t org);
    wide_t d[3], p[3][3], o[3], e1[3], e2[3], nw[3], n[3], an[3], hp[3];
    wide_t den, num, t, tq, v, lim_hi, lim_lo;
    logic [127:0] mag, mag_num, mag_den, q;
    int bl, k, ua, ub, s1, s2, s3;
    logic neg, clp;
    hit_result_t r;
    lim_hi = widen(rti_pkg::COORD_MAX);
    lim_lo = widen(rti_pkg::COORD_MIN);
    for (int c = 0; c < 3; c++) begin
      d[c] = widen(w.dir[c]);
      o[c] = widen(org[c]);
      for (int i = 0; i < 3; i++) p[i][c] = widen(w.corner[i][c]);
      e1[c] = p[1][c] - p[0][c];
      e2[c] = p[2][c] - p[0][c];
    end
    nw[0] = e1[1] * e2[2] - e1[2] * e2[1];
    nw[1] = e1[2] * e2[0] - e1[0] * e2[2];
    nw[2] = e1[0] * e2[1] - e1[1] * e2[0];
    bl = 0;
    for (int c = 0; c < 3; c++) begin
      mag = (nw[c] < 0) ? -nw[c] : nw[c];
      for (int b = 0; b < 128; b++) if (mag[b] && b + 1 > bl) bl = b + 1;
    end
    // reduce the normal to 62 magnitude bits
    k = (bl > 62) ? bl - 62 : 0;
    den = 0;
    num = 0;
    for (int c = 0; c < 3; c++) begin
      n[c] = nw[c] >>> k;
      den += n[c] * d[c];
      num += n[c] * (p[0][c] - o[c]);
    end
    r = '0;
    r.status = rti_pkg::ST_PARALLEL;
    if (den == 0) return r;
    neg = (num < 0) != (den < 0);
    mag_num = (num < 0) ? -num : num;
    mag_den = (den < 0) ? -den : den;
    q = (mag_num << rti_pkg::FRAC_BITS) / mag_den;
    clp = 1'b0;
    tq = q;
    if (!neg && q > 128'h7fffffff) begin
      t = lim_hi; clp = 1'b1;
    end else if (neg && q > 128'h80000000) begin
      t = lim_lo; clp = 1'b1;
    end else begin
      t = neg ? -tq : tq;
    end
    for (int c = 0; c < 3; c++) begin
      v = d[c] * t + (wide_t'(1) <<< (rti_pkg::FRAC_BITS - 1));
      v = (v >>> rti_pkg::FRAC_BITS) + o[c];
      if (v > lim_hi) begin
        v = lim_hi; clp = 1'b1;
      end else if (v < lim_lo) begin
        v = lim_lo; clp = 1'b1;
      end
      hp[c] = v;
    end
    for (int c = 0; c < 3; c++) an[c] = (n[c] < 0) ? -n[c] : n[c];
    // drop the dominant axis, ties go to x then y
    if (an[0] >= an[1] && an[0] >= an[2]) begin
      ua = 1; ub = 2;
    end else if (an[1] >= an[2]) begin
      ua = 0; ub = 2;
    end else begin
      ua = 0; ub = 1;
    end
    s1 = edge_sign(hp[ua], hp[ub], p[0][ua], p[0][ub], p[1][ua], p[1][ub]);
    s2 = edge_sign(hp[ua], hp[ub], p[1][ua], p[1][ub], p[2][ua], p[2][ub]);
    s3 = edge_sign(hp[ua], hp[ub], p[2][ua], p[2][ub], p[0][ua], p[0][ub]);
    r.status = ((s1 < 0 || s2 < 0 || s3 < 0) && (s1 > 0 || s2 > 0 || s3 > 0)) ?
               rti_pkg::ST_OUTSIDE : rti_pkg::ST_HIT;
    r.hx = hp[0][31:0];
    r.hy = hp[1][31:0];
    r.hz = hp[2][31:0];
    r.clamped = clp;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    hit_result_t exp_r;
    if (!rst && done) begin
      if (pending_hits.size() == 0) begin
        $error("result word with no prediction pending");
        fail_count++;
      end else begin
        exp_r = pending_hits.pop_front();
        checked++;
        if (status != exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status);
          fail_count++;
        end
        if (hit_x != exp_r.hx) begin
          $error("hit_x: expected %0d, got %0d", exp_r.hx, hit_x);
          fail_count++;
        end
        if (hit_y != exp_r.hy) begin
          $error("hit_y: expected %0d, got %0d", exp_r.hy, hit_y);
          fail_count++;
        end
        if (hit_z != exp_r.hz) begin
          $error("hit_z: expected %0d, got %0d", exp_r.hz, hit_z);
          fail_count++;
        end
        if (clamped != exp_r.clamped) begin
          $error("clamped: expected %0d, got %0d", exp_r.clamped, clamped);
          fail_count++;
        end
        case (exp_r.status)
          rti_pkg::ST_HIT:     hit_seen++;
          rti_pkg::ST_OUTSIDE: outside_seen++;
          default:             parallel_seen++;
        endcase
        if (exp_r.clamped) clamp_seen++;
      end
    end
  end

  task automatic send_word(ray_word_t w);
    dir_x <= w.dir[0]; dir_y <= w.dir[1]; dir_z <= w.dir[2];
    v0_x <= w.corner[0][0]; v0_y <= w.corner[0][1]; v0_z <= w.corner[0][2];
    v1_x <= w.corner[1][0]; v1_y <= w.corner[1][1]; v1_z <= w.corner[1][2];
    v2_x <= w.corner[2][0]; v2_y <= w.corner[2][1]; v2_z <= w.corner[2][2];
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_hits = {pending_hits, predict_intersection(w, origin_copy)};
    if (!no_idle && $urandom_range(99) < 8) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all three origin registers plus the unused index, then release we
  task automatic set_origin(rti_pkg::coord_t ox, rti_pkg::coord_t oy, rti_pkg::coord_t oz);
    cfg_we <= 1'b1; cfg_index <= rti_pkg::REG_ORIGIN_X; cfg_data <= ox;
    @(posedge clk);
    cfg_index <= rti_pkg::REG_ORIGIN_Y; cfg_data <= oy;
    @(posedge clk);
    cfg_index <= rti_pkg::REG_ORIGIN_Z; cfg_data <= oz;
    @(posedge clk);
    cfg_index <= REG_UNUSED; cfg_data <= rti_pkg::coord_t'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    origin_copy[0] = ox;
    origin_copy[1] = oy;
    origin_copy[2] = oz;
  endtask

  function automatic ray_word_t make_word(rti_pkg::coord_t dx, rti_pkg::coord_t dy,
      rti_pkg::coord_t dz, rti_pkg::coord_t ax, rti_pkg::coord_t ay, rti_pkg::coord_t az,
      rti_pkg::coord_t bx, rti_pkg::coord_t by, rti_pkg::coord_t bz,
      rti_pkg::coord_t cx, rti_pkg::coord_t cy, rti_pkg::coord_t cz);
    ray_word_t w;
    w.dir = {dz, dy, dx};
    w.corner[0] = {az, ay, ax};
    w.corner[1] = {bz, by, bx};
    w.corner[2] = {cz, cy, cx};
    return w;
  endfunction

  function automatic ray_word_t noise_word;
    ray_word_t w;
    for (int c = 0; c < 3; c++) begin
      w.dir[c] = $urandom;
      for (int i = 0; i < 3; i++) w.corner[i][c] = $urandom;
    end
    return w;
  endfunction

  // ray aimed at a point of the triangle, corners within +/-2^24 raw (256 units) of zero
  function automatic ray_word_t aimed_word;
    ray_word_t w;
    longint wt[3], sum, tgt, span;
    span = longint'(1) << $urandom_range(8, 24);
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      wt[i] = $urandom_range(0, 255);
      sum += wt[i];
    end
    if (sum == 0) begin
      wt[0] = 1; sum = 1;
    end
    for (int c = 0; c < 3; c++) begin
      tgt = 0;
      for (int i = 0; i < 3; i++) begin
        w.corner[i][c] =
          rti_pkg::coord_t'($signed(longint'($urandom_range(0, 2 * span)) - span));
        tgt += wt[i] * longint'($signed(w.corner[i][c]));
      end
      tgt = tgt / sum;
      w.dir[c] = rti_pkg::coord_t'(tgt - longint'($signed(origin_copy[c])));
    end
    return w;
  endfunction

  task automatic run_mixed(int count);
    ray_word_t w;
    int pick;
    for (int n = 0; n < count; n++) begin
      no_idle = (n % 200) >= 140;
      pick = $urandom_range(99);
      if (pick < 65) begin
        w = aimed_word();
      end else if (pick < 80) begin
        // knock the aim off the triangle
        w = aimed_word();
        w.dir[$urandom_range(2)] ^= rti_pkg::coord_t'($urandom_range(1, 1 << 22));
      end else if (pick < 85) begin
        w = noise_word();
        w.corner[1] = w.corner[0];
      end else begin
        w = noise_word();
      end
      send_word(w);
    end
    no_idle = 1'b0;
    drain();
  endtask

  task automatic test_directed;
    rti_pkg::coord_t mx, mn;
    mx = rti_pkg::COORD_MAX;
    mn = rti_pkg::COORD_MIN;
    set_origin(0, 0, 0);
    // plain hit, inside and outside, through z = 5 plane
    send_word(make_word(0, 0, ONE, -ONE, -ONE, 5*ONE, 2*ONE, -ONE, 5*ONE, -ONE, 2*ONE, 5*ONE));
    send_word(make_word(3*ONE, 3*ONE, ONE, -ONE, -ONE, 5*ONE, 2*ONE, -ONE, 5*ONE,
                        -ONE, 2*ONE, 5*ONE));
    // parallel ray and degenerate triangle
    send_word(make_word(ONE, 0, 0, -ONE, -ONE, 5*ONE, 2*ONE, -ONE, 5*ONE, -ONE, 2*ONE, 5*ONE));
    send_word(make_word(ONE, ONE, ONE, ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE,
                        ONE, 2*ONE, 3*ONE));
    // hit behind the origin
    send_word(make_word(0, 0, -ONE, -ONE, -ONE, 5*ONE, 2*ONE, -ONE, 5*ONE, -ONE, 2*ONE, 5*ONE));
    // point inside the triangle and point on a corner
    send_word(make_word(0, 0, ONE, 0, -ONE, 5*ONE, 2*ONE, ONE, 5*ONE, -2*ONE, ONE, 5*ONE));
    send_word(make_word(0, 0, ONE, 0, 0, 4*ONE, 2*ONE, 0, 4*ONE, 0, 2*ONE, 4*ONE));
    // two ties on all normal components
    send_word(make_word(ONE, ONE, ONE, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    send_word(make_word(ONE, 2*ONE, ONE, 0, ONE, 0, ONE, ONE, -ONE, ONE, 0, 0));
    // dominant y and dominant x planes
    send_word(make_word(0, ONE, 0, -ONE, 3*ONE, -ONE, 2*ONE, 3*ONE, -ONE, -ONE, 3*ONE, 2*ONE));
    send_word(make_word(ONE, 0, 0, 3*ONE, -ONE, -ONE, 3*ONE, 2*ONE, -ONE, 3*ONE, -ONE, 2*ONE));
    // tiny direction drives t into saturation
    send_word(make_word(0, 0, 1, -ONE, -ONE, mx, 2*ONE, -ONE, mx, -ONE, 2*ONE, mx));
    send_word(make_word(0, 0, -1, -ONE, -ONE, mx, 2*ONE, -ONE, mx, -ONE, 2*ONE, mx));
    // large direction saturates the point
    send_word(make_word(mx, mn, ONE, -ONE, -ONE, 1000*ONE, 2*ONE, -ONE, 1000*ONE,
                        -ONE, 2*ONE, 1000*ONE));
    // extreme corners: widest normal, reduced before the dot products
    send_word(make_word(mx, mx, mx, mn, mn, mn, mx, mn, mx, mn, mx, mx));
    send_word(make_word(mn, mn, mn, mx, mx, mn, mn, mx, mx, mx, mn, mx));
    send_word(make_word(mn, 1, mx, mn, mx, mn, mx, mx, mx, mn, mn, mx));
    send_word(make_word(-1, -1, -1, 0, 0, 0, -1, 0, 0, 0, -1, 0));
    drain();
    // same family under extreme origins
    set_origin(mx, mn, mx);
    send_word(make_word(0, 0, ONE, -ONE, -ONE, 5*ONE, 2*ONE, -ONE, 5*ONE, -ONE, 2*ONE, 5*ONE));
    send_word(make_word(mn, mx, mn, mx, mn, 0, mn, mx, 0, 0, 0, mx));
    drain();
    set_origin(mn, mx, mn);
    send_word(make_word(ONE, -ONE, ONE, -ONE, -ONE, 5*ONE, 2*ONE, -ONE, 5*ONE,
                        -ONE, 2*ONE, 5*ONE));
    send_word(make_word(mx, mx, mx, mn, mn, mn, mx, mn, mx, mn, mx, mx));
    drain();
  endtask

  task automatic test_random_origins;
    set_origin(0, 0, 0);
    run_mixed(300);
    set_origin(rti_pkg::coord_t'($urandom_range(0, 1 << 22)) - (1 << 21),
               rti_pkg::coord_t'($urandom_range(0, 1 << 22)) - (1 << 21),
               rti_pkg::coord_t'($urandom_range(0, 1 << 22)) - (1 << 21));
    run_mixed(300);
    set_origin(rti_pkg::COORD_MAX, rti_pkg::COORD_MIN, 0);
    run_mixed(130);
    set_origin(rti_pkg::coord_t'($urandom), rti_pkg::coord_t'($urandom),
               rti_pkg::coord_t'($urandom));
    run_mixed(300);
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= rti_pkg::REG_ORIGIN_X;
    cfg_data <= '0;
    {dir_x, dir_y, dir_z, v0_x, v0_y, v0_z} <= '0;
    {v1_x, v1_y, v1_z, v2_x, v2_y, v2_z} <= '0;
    origin_copy = '0;
    fail_count = 0;
    checked = 0;
    no_idle = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_origins();
    if (pending_hits.size() != 0) begin
      $error("%0d predicted results never arrived", pending_hits.size());
      fail_count++;
    end
    $display("Checked %0d results: %0d hits, %0d outside, %0d parallel, %0d saturated.",
             checked, hit_seen, outside_seen, parallel_seen, clamp_seen);
    $display("Origins covered zero, both extremes and random values.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
